// ===== rtl/bawc_pkg.sv =====
package bawc_pkg;

  localparam int WORD_BITS   = 64;
  localparam int LENGTH_BITS = 32;
  localparam int OFF_W       = $clog2(WORD_BITS);
  localparam int TAKE_W      = OFF_W + 1;
  localparam int IDX_W       = 27;
  localparam int FIFO_DEPTH  = 4;
  localparam int PTR_W       = $clog2(FIFO_DEPTH);
  localparam int CNT_W       = PTR_W + 1;

  typedef logic [WORD_BITS-1:0]   word_t;
  typedef logic [OFF_W-1:0]       off_t;
  typedef logic [TAKE_W-1:0]      take_t;
  typedef logic [LENGTH_BITS-1:0] len_t;
  typedef logic [IDX_W-1:0]       idx_t;

  typedef struct packed {
    word_t word;
    idx_t  index;
    logic  last;
  } result_t;

  typedef struct packed {
    word_t bits;
    off_t  cnt;
    len_t  left;
    idx_t  wcnt;
    logic  active;
  } copy_state_t;

  typedef struct packed {
    logic  first;
    off_t  src_offset;
    off_t  tgt_offset;
    len_t  bit_count;
    word_t tgt_head_word;
    word_t src_word;
  } item_t;

  // ones in the n lowest bits; n may equal WORD_BITS
  function automatic word_t low_mask(input take_t n);
    low_mask = ~({WORD_BITS{1'b1}} << n);
  endfunction

endpackage

// ===== rtl/bawc_step.sv =====
module bawc_step import bawc_pkg::*; (
  input  copy_state_t      st,
  input  item_t            item,
  output copy_state_t      st_nxt,
  output result_t          res0,
  output result_t          res1,
  output logic [1:0]       res_n
);

  word_t pb;
  off_t  pc;
  len_t  bl;
  idx_t  wc;
  word_t data;
  take_t take;
  word_t merged;
  word_t rest;
  take_t total;
  len_t  bl_left;
  logic  full;
  logic  tail;
  logic  run;
  word_t pb_new;
  off_t  pc_new;
  idx_t  wc_full;

  always_comb begin
    pb   = st.bits;
    pc   = st.cnt;
    bl   = st.left;
    wc   = st.wcnt;
    run  = st.active;
    data = item.src_word;
    take = take_t'(WORD_BITS);
    if (item.first) begin
      bl   = item.bit_count;
      wc   = '0;
      pc   = item.tgt_offset;
      pb   = item.tgt_head_word & low_mask(take_t'(item.tgt_offset));
      run  = (item.bit_count != '0);
      data = item.src_word >> item.src_offset;
      take = take_t'(WORD_BITS) - take_t'(item.src_offset);
    end
    if (bl < len_t'(take)) begin
      take = bl[TAKE_W-1:0];
    end
    data    = data & low_mask(take);
    merged  = pb | (data << pc);
    total   = take_t'(pc) + take;
    bl_left = bl - len_t'(take);
    full    = total >= take_t'(WORD_BITS);
    // bits of data that spill past the completed word
    rest    = (pc != '0) ? (data >> (take_t'(WORD_BITS) - take_t'(pc))) : '0;
    pb_new  = full ? rest : merged;
    pc_new  = full ? off_t'(total - take_t'(WORD_BITS)) : off_t'(total);
    wc_full = full ? wc + idx_t'(1) : wc;
    tail    = (bl_left == '0) && (pc_new != '0);

    res0.word  = full ? merged : pb_new;
    res0.index = wc;
    res0.last  = full ? ((bl_left == '0) && (pc_new == '0)) : 1'b1;
    res1.word  = pb_new;
    res1.index = wc_full;
    res1.last  = 1'b1;

    st_nxt = st;
    res_n  = 2'd0;
    if (item.first && !run) begin
      // zero-length copy: clear and stay idle
      st_nxt.bits   = '0;
      st_nxt.cnt    = '0;
      st_nxt.left   = bl;
      st_nxt.wcnt   = '0;
      st_nxt.active = 1'b0;
    end else if (run) begin
      res_n         = {1'b0, full} + {1'b0, tail};
      st_nxt.left   = bl_left;
      st_nxt.wcnt   = wc_full + (tail ? idx_t'(1) : idx_t'(0));
      if (bl_left == '0) begin
        st_nxt.bits   = '0;
        st_nxt.cnt    = '0;
        st_nxt.active = 1'b0;
      end else begin
        st_nxt.bits   = pb_new;
        st_nxt.cnt    = pc_new;
        st_nxt.active = 1'b1;
      end
    end
  end

endmodule

// ===== rtl/bawc_ofifo.sv =====
module bawc_ofifo import bawc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [1:0]  push_n,
  input  result_t     push0,
  input  result_t     push1,
  output logic        room2,
  output logic        out_valid,
  input  logic        out_stall,
  output result_t     out_res
);

  result_t              mem_r [FIFO_DEPTH];
  logic [PTR_W-1:0]     wr_r, wr_nxt;
  logic [PTR_W-1:0]     rd_r, rd_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 pop;
  logic [PTR_W-1:0]     wr_p1;

  assign out_valid = (cnt_r != '0);
  assign out_res   = mem_r[rd_r];
  assign pop       = out_valid && !out_stall;
  assign room2     = cnt_r <= CNT_W'(FIFO_DEPTH - 2);
  assign wr_p1     = wr_r + PTR_W'(1);

  always_comb begin
    wr_nxt  = wr_r + PTR_W'(push_n);
    rd_nxt  = rd_r + (pop ? PTR_W'(1) : PTR_W'(0));
    cnt_nxt = cnt_r + CNT_W'(push_n) - (pop ? CNT_W'(1) : CNT_W'(0));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem_r[wr_r] <= push0;
    end
    if (push_n == 2'd2) begin
      mem_r[wr_p1] <= push1;
    end
  end

endmodule

// ===== rtl/bit_aligned_word_copier.sv =====
// Results: an accepted item's result words are written into the output queue and are
// offered in order; a second word of the same item is queued right behind the first.
// Throughput: one item per cycle; the item closing a copy may add a second word, and
// input is held off while more than two words wait in the four-entry output queue.
// Reset (rst_n, synchronous, active low) empties the queue and leaves the
// copier idle with no partial word held.
module bit_aligned_word_copier import bawc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   in_first,
  input  logic [OFF_W-1:0]       in_src_offset,
  input  logic [OFF_W-1:0]       in_tgt_offset,
  input  logic [LENGTH_BITS-1:0] in_bit_count,
  input  logic [WORD_BITS-1:0]   in_tgt_head_word,
  input  logic [WORD_BITS-1:0]   in_src_word,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [WORD_BITS-1:0]   out_word,
  output logic [IDX_W-1:0]       out_index,
  output logic                   out_last
);

  copy_state_t st_r, st_nxt, st_step;
  item_t       item;
  result_t     res0, res1, out_res;
  logic [1:0]  res_n;
  logic [1:0]  push_n;
  logic        room2;
  logic        accept;

  assign item.first         = in_first;
  assign item.src_offset    = in_src_offset;
  assign item.tgt_offset    = in_tgt_offset;
  assign item.bit_count     = in_bit_count;
  assign item.tgt_head_word = in_tgt_head_word;
  assign item.src_word      = in_src_word;

  assign in_stall = !room2;
  assign accept   = in_valid && room2;

  bawc_step u_step (
    .st     (st_r),
    .item   (item),
    .st_nxt (st_step),
    .res0   (res0),
    .res1   (res1),
    .res_n  (res_n)
  );

  assign st_nxt = accept ? st_step : st_r;
  assign push_n = accept ? res_n : 2'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else begin
      st_r <= st_nxt;
    end
  end

  bawc_ofifo u_ofifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_n    (push_n),
    .push0     (res0),
    .push1     (res1),
    .room2     (room2),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_word  = out_res.word;
  assign out_index = out_res.index;
  assign out_last  = out_res.last;

endmodule
